[src/ansi_escape_terminal_cursor_macros.svh]
// Assertion macros shared by the checker of the terminal cursor block.
// Depends on nothing; include by bare file name.
`ifndef ANSI_ESCAPE_TERMINAL_CURSOR_MACROS_SVH
`define ANSI_ESCAPE_TERMINAL_CURSOR_MACROS_SVH
`define AETC_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define AETC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`endif

[src/aetc_pkg.sv]
// Package of the terminal cursor block: types, codes and constants.
// Depends on nothing.
package aetc_pkg;
    typedef enum logic [3:0] {
        PS_START = 4'd0, PS_ESC = 4'd1, PS_BRACKET = 4'd2, PS_NUM1 = 4'd3,
        PS_SEMI = 4'd4, PS_NUM2 = 4'd5, PS_QUEST = 4'd6, PS_NUM3 = 4'd7,
        PS_PAGE = 4'd8
    } parse_state_t;

    typedef enum logic [2:0] {
        ACT_NONE = 3'd0, ACT_DRAW = 3'd1, ACT_ERASE = 3'd2, ACT_CLR_LINE = 3'd3,
        ACT_CLR_DISP = 3'd4, ACT_SCROLL = 3'd5, ACT_DRAW_SCROLL = 3'd6
    } action_t;

    // Classified operation handed from the front part to the back part.
    typedef enum logic [4:0] {
        OP_NOP, OP_BS, OP_TAB, OP_LF, OP_CR, OP_GLYPH, OP_UP, OP_DOWN,
        OP_RIGHT, OP_LEFT, OP_HOME, OP_CLR_DISP, OP_CLR_LINE, OP_ERASE,
        OP_INSERT, OP_SGR, OP_GOTO, OP_REGION, OP_CURSOR, OP_PAGE
    } op_t;

    localparam logic [0:0] REG_COLUMNS = 1'b0;
    localparam logic [0:0] REG_ROWS = 1'b1;

    typedef struct packed {
        op_t        op;
        logic [7:0] data;
        logic [7:0] num1;
        logic [7:0] num2;
        logic       flag;
    } cmd_t;

    typedef struct packed {
        logic [2:0] action;
        logic [7:0] glyph;
        logic [7:0] at_column;
        logic [7:0] at_row;
        logic [8:0] span;
        logic [4:0] fg_index;
        logic [4:0] bg_index;
        logic [7:0] region_top;
        logic [8:0] region_end;
        logic [7:0] cursor_column;
        logic [7:0] cursor_row;
        logic       cursor_shown;
    } result_t;

    localparam logic [4:0] COLOR_NORMAL = 5'd16;
    localparam logic [4:0] COLOR_HIGH = 5'd17;
    localparam logic [4:0] COLOR_HALF = 5'd18;
endpackage

[src/aetc_stream_if.sv]
// Valid/ready stream interface for the terminal cursor block.
// Depends on nothing but its width parameter.
interface aetc_stream_if #(parameter int W = 8);
    logic         valid;
    logic         ready;
    logic [W-1:0] payload;
    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

[src/aetc_front.sv]
// Front part: escape sequence parser that turns bytes into commands.
// Depends on aetc_pkg.
module aetc_front
    import aetc_pkg::*;
#(
    parameter int MAX_NUMBER = 199
)(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    input  logic [7:0] in_byte,
    output logic       in_ready,
    output logic       cmd_valid,
    output cmd_t       cmd,
    input  logic       cmd_ready
);
    parse_state_t state_reg, state_next;
    logic [7:0] num1_reg, num1_next, num2_reg, num2_next;
    logic [7:0] b;
    logic       dig;
    logic [3:0] dv;
    logic [11:0] acc1, acc2;
    logic       take;

    assign in_ready = cmd_ready;
    assign cmd_valid = in_valid;
    assign take = in_valid && cmd_ready;
    assign b = in_byte;
    assign dig = (b >= 8'h30) && (b <= 8'h39);
    assign dv = b[3:0];
    assign acc1 = {4'd0, num1_reg} * 12'd10 + {8'd0, dv};
    assign acc2 = {4'd0, num2_reg} * 12'd10 + {8'd0, dv};

    always_comb
    begin
        state_next = PS_START;
        num1_next = num1_reg;
        num2_next = num2_reg;
        cmd = '{op: OP_NOP, data: b, num1: num1_reg, num2: num2_reg, flag: 1'b0};
        case (state_reg)
            PS_START:
            begin
                if (b == 8'h08) cmd.op = OP_BS;
                else if (b == 8'h09) cmd.op = OP_TAB;
                else if (b == 8'h0A) cmd.op = OP_LF;
                else if (b == 8'h0D) cmd.op = OP_CR;
                else if (b == 8'h1B) state_next = PS_ESC;
                else if (b >= 8'h20) cmd.op = OP_GLYPH;
            end
            PS_ESC:
            begin
                if (b == "[") state_next = PS_BRACKET;
                else if (b == "d") state_next = PS_PAGE;
            end
            PS_BRACKET:
            begin
                if (b == "?") state_next = PS_QUEST;
                else if (b == "A") cmd.op = OP_UP;
                else if (b == "B") cmd.op = OP_DOWN;
                else if (b == "C") cmd.op = OP_RIGHT;
                else if (b == "D") cmd.op = OP_LEFT;
                else if (b == "H") cmd.op = OP_HOME;
                else if (b == "J") cmd.op = OP_CLR_DISP;
                else if (b == "K") cmd.op = OP_CLR_LINE;
                else if (dig)
                begin
                    num1_next = {4'd0, dv};
                    state_next = PS_NUM1;
                end
            end
            PS_NUM1:
            begin
                if (b == ";") state_next = PS_SEMI;
                else if (b == "X") cmd.op = OP_ERASE;
                else if (b == "h" || b == "l")
                begin
                    if (num1_reg == 8'd4) cmd.op = OP_INSERT;
                    cmd.flag = (b == "h");
                end
                else if (b == "m") cmd.op = OP_SGR;
                else if (dig && acc1 <= 12'(MAX_NUMBER))
                begin
                    num1_next = acc1[7:0];
                    state_next = PS_NUM1;
                end
            end
            PS_SEMI:
            begin
                if (dig)
                begin
                    num2_next = {4'd0, dv};
                    state_next = PS_NUM2;
                end
            end
            PS_NUM2:
            begin
                if (b == "H") cmd.op = OP_GOTO;
                else if (b == "r") cmd.op = OP_REGION;
                else if (dig && acc2 <= 12'(MAX_NUMBER))
                begin
                    num2_next = acc2[7:0];
                    state_next = PS_NUM2;
                end
            end
            PS_QUEST:
            begin
                if (dig)
                begin
                    num1_next = {4'd0, dv};
                    state_next = PS_NUM3;
                end
            end
            PS_NUM3:
            begin
                if (b == "h" || b == "l")
                begin
                    if (num1_reg == 8'd25) cmd.op = OP_CURSOR;
                    cmd.flag = (b == "h");
                end
                else if (dig && acc1 <= 12'd99)
                begin
                    num1_next = acc1[7:0];
                    state_next = PS_NUM3;
                end
            end
            PS_PAGE:
            begin
                if (b == "+" || b == "*") cmd.op = OP_PAGE;
                cmd.flag = (b == "+");
            end
            default: state_next = PS_START;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= PS_START;
            num1_reg <= '0;
            num2_reg <= '0;
        end
        else if (take)
        begin
            state_reg <= state_next;
            num1_reg <= num1_next;
            num2_reg <= num2_next;
        end
    end
endmodule

[src/aetc_queue.sv]
// Two-entry command queue between the parser and the executor.
// Depends on aetc_pkg.
module aetc_queue
    import aetc_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    input  cmd_t in_cmd,
    output logic in_ready,
    output logic out_valid,
    output cmd_t out_cmd,
    input  logic out_ready
);
    cmd_t mem_reg [2];
    logic wp_reg, rp_reg;
    logic [1:0] cnt_reg;
    logic push, pop;

    assign in_ready = (cnt_reg != 2'd2);
    assign out_valid = (cnt_reg != 2'd0);
    assign out_cmd = mem_reg[rp_reg];
    assign push = in_valid && in_ready;
    assign pop = out_valid && out_ready;

    always_ff @(posedge clk)
    begin
        if (push) mem_reg[wp_reg] <= in_cmd;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg <= 1'b0;
            rp_reg <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            if (push) wp_reg <= ~wp_reg;
            if (pop) rp_reg <= ~rp_reg;
            cnt_reg <= cnt_reg + 2'(push) - 2'(pop);
        end
    end
endmodule

[src/aetc_back.sv]
// Back part: executes commands on the cursor, region and color state.
// Depends on aetc_pkg.
module aetc_back
    import aetc_pkg::*;
#(
    parameter int MAX_COLUMNS = 256
)(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cmd_valid,
    input  cmd_t       cmd,
    output logic       cmd_ready,
    output logic       res_valid,
    output result_t    res,
    input  logic       res_ready,
    input  logic       cfg_we,
    input  logic [0:0] cfg_idx,
    input  logic [8:0] cfg_data,
    output logic [8:0] columns,
    output logic [8:0] rows
);
    logic [8:0] cols_reg, rows_reg;
    logic [7:0] col_reg, col_next, row_reg, row_next, top_reg, top_next;
    logic [8:0] end_reg, end_next;
    logic [4:0] fg_reg, fg_next, bg_reg, bg_next;
    logic cur_reg, cur_next, rev_reg, rev_next, ins_reg, ins_next, pg_reg, pg_next;
    logic [8:0] ecols, erows;
    logic [9:0] c1, r1, tabv;
    logic       scroll, take, out_v_reg;
    result_t    out_reg, r;
    logic [7:0] n1, n2, code;

    assign columns = cols_reg;
    assign rows = rows_reg;
    assign cmd_ready = !out_v_reg || res_ready;
    assign take = cmd_valid && cmd_ready;
    assign res_valid = out_v_reg;
    assign res = out_reg;
    assign n1 = cmd.num1;
    assign n2 = cmd.num2;
    assign code = cmd.num1;

    always_comb
    begin
        ecols = cols_reg;
        if (cols_reg == 9'd0) ecols = 9'd1;
        else if (cols_reg > 9'(MAX_COLUMNS)) ecols = 9'(MAX_COLUMNS);
        erows = rows_reg;
        if (rows_reg == 9'd0) erows = 9'd1;
        else if (rows_reg > 9'd256) erows = 9'd256;
    end

    always_comb
    begin
        col_next = col_reg; row_next = row_reg; top_next = top_reg; end_next = end_reg;
        fg_next = fg_reg; bg_next = bg_reg; cur_next = cur_reg; rev_next = rev_reg;
        ins_next = ins_reg; pg_next = pg_reg;
        scroll = 1'b0;
        r = '0;
        c1 = {2'd0, col_reg} + 10'd1;
        r1 = {2'd0, row_reg} + 10'd1;
        tabv = {2'd0, col_reg[7:3], 3'd0} + 10'd8;
        case (cmd.op)
            OP_BS, OP_LEFT:
            begin
                if (col_reg != 8'd0) col_next = col_reg - 8'd1;
                else if (row_reg > top_reg)
                begin
                    col_next = 8'(ecols - 9'd1);
                    row_next = row_reg - 8'd1;
                end
            end
            OP_CR: col_next = 8'd0;
            OP_UP: if (row_reg > top_reg) row_next = row_reg - 8'd1;
            OP_HOME:
            begin
                col_next = 8'd0;
                row_next = top_reg;
            end
            OP_TAB, OP_LF, OP_GLYPH, OP_RIGHT, OP_DOWN:
            begin
                if (cmd.op == OP_GLYPH)
                begin
                    r.action = ACT_DRAW; r.glyph = cmd.data;
                    r.at_column = col_reg; r.at_row = row_reg;
                end
                if (cmd.op == OP_TAB && tabv < {1'b0, ecols}) col_next = tabv[7:0];
                else if ((cmd.op == OP_GLYPH || cmd.op == OP_RIGHT)
                         && c1 < {1'b0, ecols}) col_next = c1[7:0];
                else
                begin
                    if (cmd.op != OP_DOWN) col_next = 8'd0;
                    if (r1 >= {1'b0, end_reg})
                    begin
                        if (pg_reg) row_next = 8'd0;
                        else scroll = 1'b1;
                    end
                    else row_next = r1[7:0];
                end
                if (scroll) r.action = (cmd.op == OP_GLYPH) ? ACT_DRAW_SCROLL : ACT_SCROLL;
            end
            OP_CLR_DISP, OP_CLR_LINE:
            begin
                r.action = (cmd.op == OP_CLR_DISP) ? ACT_CLR_DISP : ACT_CLR_LINE;
                r.at_column = col_reg; r.at_row = row_reg;
                r.span = ecols - {1'b0, col_reg};
            end
            OP_ERASE:
            begin
                if (n1 != 8'd0)
                begin
                    r.action = ACT_ERASE;
                    r.at_column = col_reg; r.at_row = row_reg;
                    r.span = ecols - {1'b0, col_reg};
                    if ({1'b0, n1} < r.span) r.span = {1'b0, n1};
                end
            end
            OP_INSERT: ins_next = cmd.flag;
            OP_CURSOR: cur_next = cmd.flag;
            OP_PAGE: pg_next = cmd.flag;
            OP_SGR:
            begin
                if (code == 8'd0 || code == 8'd27)
                begin
                    rev_next = 1'b0; fg_next = COLOR_NORMAL;
                end
                else if (code == 8'd1) fg_next = COLOR_HIGH;
                else if (code == 8'd2) fg_next = COLOR_HALF;
                else if (code == 8'd7) rev_next = 1'b1;
                else if (code >= 8'd30 && code <= 8'd37) fg_next = 5'(code - 8'd30);
                else if (code >= 8'd40 && code <= 8'd47) bg_next = 5'(code - 8'd40);
                else if (code >= 8'd90 && code <= 8'd97) fg_next = 5'(code - 8'd82);
                else if (code >= 8'd100 && code <= 8'd107) bg_next = 5'(code - 8'd92);
            end
            OP_GOTO:
            begin
                if (n1 != 8'd0 && n2 != 8'd0 && {1'b0, n2 - 8'd1} < ecols
                    && (n1 - 8'd1) >= top_reg && {1'b0, n1 - 8'd1} < end_reg)
                begin
                    col_next = n2 - 8'd1;
                    row_next = n1 - 8'd1;
                end
            end
            OP_REGION:
            begin
                row_next = top_reg;
                if (n1 != 8'd0 && {1'b0, n1 - 8'd1} < erows && n2 != 8'd0
                    && {1'b0, n2} <= erows && (n1 - 8'd1) < n2)
                begin
                    top_next = n1 - 8'd1;
                    end_next = {1'b0, n2};
                    row_next = n1 - 8'd1;
                end
                col_next = 8'd0;
            end
            default: ;
        endcase
        r.fg_index = rev_next ? bg_next : fg_next;
        r.bg_index = rev_next ? fg_next : bg_next;
        r.region_top = top_next;
        r.region_end = end_next;
        r.cursor_column = col_next;
        r.cursor_row = row_next;
        r.cursor_shown = cur_next;
    end

    always_ff @(posedge clk)
    begin
        if (take) out_reg <= r;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cols_reg <= 9'd80; rows_reg <= 9'd25;
            col_reg <= '0; row_reg <= '0; top_reg <= '0; end_reg <= 9'd25;
            fg_reg <= COLOR_NORMAL; bg_reg <= '0;
            cur_reg <= 1'b1; rev_reg <= 1'b0; ins_reg <= 1'b0; pg_reg <= 1'b0;
            out_v_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            if (cfg_idx == REG_COLUMNS) cols_reg <= cfg_data;
            else
            begin
                rows_reg <= cfg_data;
            end
            top_reg <= '0;
            end_reg <= (cfg_idx == REG_ROWS)
                       ? ((cfg_data == 9'd0) ? 9'd1
                          : ((cfg_data > 9'd256) ? 9'd256 : cfg_data))
                       : erows;
            col_reg <= '0; row_reg <= '0;
        end
        else
        begin
            if (take)
            begin
                col_reg <= col_next; row_reg <= row_next; top_reg <= top_next;
                end_reg <= end_next; fg_reg <= fg_next; bg_reg <= bg_next;
                cur_reg <= cur_next; rev_reg <= rev_next; ins_reg <= ins_next;
                pg_reg <= pg_next;
            end
            if (take) out_v_reg <= 1'b1;
            else if (res_ready) out_v_reg <= 1'b0;
        end
    end
endmodule

[src/ansi_escape_terminal_cursor.sv]
// Top level of the terminal cursor block: parser, queue and executor.
// Depends on aetc_pkg, aetc_stream_if, aetc_front, aetc_queue and aetc_back.
//
// Bytes of a terminal stream enter on the in channel, one per transaction.
// Every byte yields exactly one command transaction on the out channel
// carrying the drawing action and the cursor, region and color state.
// The parser classifies a byte in the cycle it is accepted; the command
// passes a two-entry queue and the executor registers the result. One
// byte per cycle is sustained while the receiver keeps out.ready high.
// The executor's output register and the queue let bytes be accepted while a
// result waits; when the receiver stalls, the queue fills and then in.ready
// drops. Reset puts the parser at start, cursor and region at full screen,
// columns at 80 and rows at 25. Writing columns (address 0) or rows
// (address 4) homes the cursor and resets the scroll region; write only while
// no transaction is in flight.
module ansi_escape_terminal_cursor
    import aetc_pkg::*;
#(
    parameter int MAX_COLUMNS = 256,
    parameter int MAX_NUMBER = 199
)(
    input  logic        clk,
    input  logic        rst_n,
    aetc_stream_if.sink   in_ch,
    aetc_stream_if.source out_ch,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    logic f_valid, f_ready, q_valid, q_ready, cfg_we;
    cmd_t f_cmd, q_cmd;
    result_t res;
    logic [8:0] columns, rows;

    assign pready = 1'b1;
    assign cfg_we = psel && penable && pwrite && (paddr[1:0] == 2'd0) && (paddr[2] <= 1'b1);
    assign prdata = {23'd0, (paddr[2] == REG_ROWS) ? rows : columns};
    assign out_ch.payload = res;

    aetc_front #(.MAX_NUMBER(MAX_NUMBER)) u_front (
        .clk(clk), .rst_n(rst_n), .in_valid(in_ch.valid), .in_byte(in_ch.payload),
        .in_ready(in_ch.ready), .cmd_valid(f_valid), .cmd(f_cmd), .cmd_ready(f_ready)
    );

    aetc_queue u_queue (
        .clk(clk), .rst_n(rst_n), .in_valid(f_valid), .in_cmd(f_cmd), .in_ready(f_ready),
        .out_valid(q_valid), .out_cmd(q_cmd), .out_ready(q_ready)
    );

    aetc_back #(.MAX_COLUMNS(MAX_COLUMNS)) u_back (
        .clk(clk), .rst_n(rst_n), .cmd_valid(q_valid), .cmd(q_cmd), .cmd_ready(q_ready),
        .res_valid(out_ch.valid), .res(res), .res_ready(out_ch.ready),
        .cfg_we(cfg_we), .cfg_idx(paddr[2]), .cfg_data(pwdata[8:0]),
        .columns(columns), .rows(rows)
    );
endmodule

[src/aetc_checker.sv]
// Port-level checker for the terminal cursor block, bound to the top level.
// Depends on the assertion macro header.
`include "ansi_escape_terminal_cursor_macros.svh"
module aetc_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic [79:0] out_payload
);
    `AETC_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid)
    `AETC_ASSERT_NEXT(a_out_stable, clk, rst_n, out_valid && !out_ready, $stable(out_payload))
    `AETC_ASSERT_IMPL(a_ready_when_idle, clk, rst_n, !out_valid, in_ready)
    `AETC_ASSERT_IMPL(a_action_range, clk, rst_n, out_valid, out_payload[79:77] != 3'd7)
endmodule

bind ansi_escape_terminal_cursor aetc_checker u_aetc_checker (
    .clk(clk), .rst_n(rst_n), .in_valid(in_ch.valid), .in_ready(in_ch.ready),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready), .out_payload(out_ch.payload)
);
